// ===== sv/lpld_pkg.sv =====
// Shared types and constants for the piecewise-linear distance lookup.
// Used by the table RAM, the serial divider and the top level.
package lpld_pkg;

    localparam int IDX_W      = 6;
    localparam int LEN_W      = 7;
    localparam int LEVEL_W    = 32;
    localparam int DIST_W     = 16;
    localparam int QUAL_W     = 8;
    localparam int DIVIDEND_W = LEVEL_W + DIST_W;
    localparam int SUM_W      = DIVIDEND_W + 1;
    localparam int CNT_W      = $clog2(DIVIDEND_W);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [QUAL_W-1:0] EMPTY_QUAL = 8'd3;
    localparam logic [DIST_W-1:0] DIST_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DIST_W-1:0]  distance;
        logic [QUAL_W-1:0]  qual;
    } t_entry;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [LEVEL_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/lut_piecewise_linear_distance.sv =====
// Piecewise-linear distance lookup: table RAM, binary search, serial divide.
// Write items go straight into the table RAM. A convert item gives an empty-table result without
// reading the table, a clamped result after reading the first and, if needed, the last entry,
// or an interpolated result after a binary search (one table read per step), a multiply and the serial divide.
// One item at a time; the result waits in an output register. Reset is synchronous active
// low; it clears control state and the length register; table contents undefined until written.
module lut_piecewise_linear_distance import lpld_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_index, entry_level, entry_distance, entry_quality, sample_level, pad
    input  logic [95:0]      s_axis_tdata,
    // operation
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // distance, quality
    output logic [23:0]      m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = AW + IDX_W + 1;
    localparam int CW = AW + LEN_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIRST = 10'b0000000010,
        S_LAST  = 10'b0000000100,
        S_SRCH  = 10'b0000001000,
        S_RDLO  = 10'b0000010000,
        S_RDHI  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIVS  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [LEN_W-1:0]      r_tab_len;
    logic [LEVEL_W-1:0]    r_x, n_x;
    logic [NW-1:0]         r_n, n_n;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [AW-1:0]         r_mid, n_mid;
    t_entry                r_lo_ent, n_lo_ent;
    logic [DIST_W-1:0]     r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [LEVEL_W-1:0]    r_off, n_off;
    logic [LEVEL_W-1:0]    r_span, n_span;
    logic [DIVIDEND_W-1:0] r_prod, n_prod;
    logic [DIST_W-1:0]     r_res_d, n_res_d;
    logic [QUAL_W-1:0]     r_res_q, n_res_q;

    logic                  r_m_valid;
    logic [DIST_W-1:0]     r_m_dist;
    logic [QUAL_W-1:0]     r_m_qual;

    logic                  s_acc;
    logic                  in_op;
    logic [IDX_W-1:0]      in_idx;
    logic [XW-1:0]         in_idx_x;
    logic                  idx_ok;
    t_entry                in_ent;
    logic [LEVEL_W-1:0]    in_sample;
    logic [CW-1:0]         len_x;
    logic [CW-1:0]         n_c;

    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_entry                rd_data;

    t_div_req              div_req;
    t_div_rsp              div_rsp;

    logic                  out_load;
    logic                  srch_ge;
    logic [AW-1:0]         s_lo, s_hi;
    logic [AW:0]           mid_sum;
    logic [LEVEL_W-1:0]    span_c;
    logic [QUAL_W-1:0]     qmax_c;
    logic [SUM_W-1:0]      sum_c;

    assign in_op     = s_axis_tuser;
    assign in_idx    = s_axis_tdata[5:0];
    assign in_ent    = '{level: s_axis_tdata[37:6], distance: s_axis_tdata[53:38],
                         qual: s_axis_tdata[61:54]};
    assign in_sample = s_axis_tdata[93:62];
    assign in_idx_x  = XW'(in_idx);
    assign idx_ok    = in_idx_x < XW'(TABLE_DEPTH);

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s_acc && (in_op == OP_WRITE) && idx_ok;

    assign len_x = CW'(r_tab_len);
    assign n_c   = (len_x < CW'(TABLE_DEPTH)) ? len_x : CW'(TABLE_DEPTH);

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign srch_ge = rd_data.level >= r_x;
    assign span_c  = r_lo_ent.level - rd_data.level;
    assign qmax_c  = (rd_data.qual > r_lo_ent.qual) ? rd_data.qual : r_lo_ent.qual;
    assign sum_c   = SUM_W'(r_lo_ent.distance) + SUM_W'(div_rsp.quotient);

    lpld_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (in_idx_x[AW-1:0]),
        .i_wdata (in_ent),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lpld_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = (r_state == S_DIVS);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_span;

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_n      = r_n;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_lo_ent = r_lo_ent;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_off    = r_off;
        n_span   = r_span;
        n_prod   = r_prod;
        n_res_d  = r_res_d;
        n_res_q  = r_res_q;
        rd_en    = 1'b0;
        rd_addr  = '0;
        s_lo     = r_lo;
        s_hi     = r_hi;
        mid_sum  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && (in_op == OP_CONVERT)) begin
                    n_x = in_sample;
                    n_n = n_c[NW-1:0];
                    if (r_tab_len == '0) begin
                        n_res_d = '0;
                        n_res_q = EMPTY_QUAL;
                        n_state = S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (r_x >= rd_data.level) begin
                    n_res_d = rd_data.distance;
                    n_res_q = rd_data.qual;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_n - NW'(1));
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_x <= rd_data.level) begin
                    n_res_d = rd_data.distance;
                    n_res_q = rd_data.qual;
                    n_state = S_OUT;
                end else begin
                    s_lo    = '0;
                    s_hi    = AW'(r_n - NW'(1));
                    mid_sum = (AW+1)'(s_lo) + (AW+1)'(s_hi) + (AW+1)'(1);
                    n_lo    = s_lo;
                    n_hi    = s_hi;
                    n_mid   = mid_sum[AW:1];
                    rd_en   = 1'b1;
                    rd_addr = mid_sum[AW:1];
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                s_lo    = srch_ge ? r_mid : r_lo;
                s_hi    = srch_ge ? r_hi : (r_mid - AW'(1));
                mid_sum = (AW+1)'(s_lo) + (AW+1)'(s_hi) + (AW+1)'(1);
                n_lo    = s_lo;
                n_hi    = s_hi;
                rd_en   = 1'b1;
                if (s_lo < s_hi) begin
                    n_mid   = mid_sum[AW:1];
                    rd_addr = mid_sum[AW:1];
                end else begin
                    rd_addr = s_lo;
                    n_state = S_RDLO;
                end
            end
            S_RDLO: begin
                n_lo_ent = rd_data;
                if ((NW'(r_lo) + NW'(1)) >= r_n) begin
                    n_res_d = rd_data.distance;
                    n_res_q = rd_data.qual;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_lo + AW'(1);
                    n_state = S_RDHI;
                end
            end
            S_RDHI: begin
                n_res_q = qmax_c;
                if (span_c == '0) begin
                    n_res_d = r_lo_ent.distance;
                    n_state = S_OUT;
                end else begin
                    n_span  = span_c;
                    n_off   = r_lo_ent.level - r_x;
                    n_neg   = rd_data.distance < r_lo_ent.distance;
                    n_mag   = (rd_data.distance < r_lo_ent.distance) ?
                              (r_lo_ent.distance - rd_data.distance) :
                              (rd_data.distance - r_lo_ent.distance);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = DIVIDEND_W'(r_mag) * DIVIDEND_W'(r_off);
                n_state = S_DIVS;
            end
            S_DIVS: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_neg) begin
                        if (div_rsp.quotient > DIVIDEND_W'(r_lo_ent.distance)) begin
                            n_res_d = '0;
                        end else begin
                            n_res_d = r_lo_ent.distance - div_rsp.quotient[DIST_W-1:0];
                        end
                    end else if (sum_c > SUM_W'(DIST_MAX)) begin
                        n_res_d = DIST_MAX;
                    end else begin
                        n_res_d = sum_c[DIST_W-1:0];
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tab_len <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tab_len <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_n      <= n_n;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_lo_ent <= n_lo_ent;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_off    <= n_off;
        r_span   <= n_span;
        r_prod   <= n_prod;
        r_res_d  <= n_res_d;
        r_res_q  <= n_res_q;
        if (out_load) begin
            r_m_dist <= r_res_d;
            r_m_qual <= r_res_q;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_qual, r_m_dist};

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == S_IDLE)
        else $error("table write outside idle");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_op == OP_CONVERT) && r_tab_len == '0) |=>
        (r_state == S_OUT && r_res_q == EMPTY_QUAL && r_res_d == '0))
        else $error("empty table result wrong");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi && r_mid > r_lo && r_mid <= r_hi))
        else $error("search bounds out of order");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider done outside divide state");

endmodule

// ===== sv/lpld_table_ram.sv =====
// Calibration table storage: one write port, one registered read port.
// Depends on lpld_pkg for the entry type.
module lpld_table_ram import lpld_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lpld_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lpld_pkg for widths and the request/response structs.
module lpld_div import lpld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [LEVEL_W-1:0]    r_rem;
    logic [LEVEL_W-1:0]    r_dvs;

    logic [LEVEL_W:0]      rem_sh;
    logic [LEVEL_W:0]      rem_sub;
    logic                  q_bit;

    assign rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], q_bit};
            r_rem <= rem_sub[LEVEL_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
